>>> rtl/oal_pkg.sv
// Package with operation codes, status codes and the cell control type of the ordered list.
`timescale 1ns / 1ps

package oal_pkg;

  // Operation codes of an input transfer.
  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_INS_AT    = 3'd1;
  localparam logic [2:0] OP_DEL_AT    = 3'd2;
  localparam logic [2:0] OP_INS_FIRST = 3'd3;
  localparam logic [2:0] OP_INS_LAST  = 3'd4;
  localparam logic [2:0] OP_DEL_FIRST = 3'd5;
  localparam logic [2:0] OP_DEL_LAST  = 3'd6;

  // Status codes of a result transfer.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Cell commands broadcast along the chain.
  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Control broadcast to every cell in the same cycle.
  typedef struct packed {
    logic [1:0] cmd;
    logic       rd;
  } cell_ctl_t;

endpackage

>>> rtl/oal_cell.sv
// One storage cell of the list chain: holds, shifts up, shifts down or loads one entry.
`timescale 1ns / 1ps

module oal_cell #(
  parameter int PW  = 8,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  oal_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]     pos,
  input  oal_pkg::word_t    value,
  input  oal_pkg::word_t    left_word,
  input  oal_pkg::word_t    right_word,
  output oal_pkg::word_t    word,
  output oal_pkg::word_t    rd_word
);
  import oal_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  word_t word_r, word_nxt;
  word_t rd_word_r, rd_word_nxt;

  // Insert opens a slot at pos; delete closes the slot at pos.
  always_comb begin
    word_nxt = word_r;
    case (ctl.cmd)
      CMD_INS: begin
        if (MY_IDX > pos) word_nxt = left_word;
        else if (MY_IDX == pos) word_nxt = value;
      end
      CMD_DEL: begin
        if (MY_IDX >= pos) word_nxt = right_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  // The addressed cell drives its word into the read tree; all others drive zero.
  assign rd_word_nxt = (ctl.rd && (MY_IDX == pos)) ? word_r : '0;

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    rd_word_r <= rd_word_nxt;
  end

  assign word    = word_r;
  assign rd_word = rd_word_r;

endmodule

>>> rtl/oal_rd_tree.sv
// Two-stage registered OR tree that collects the one addressed word from the cell chain.
`timescale 1ns / 1ps

module oal_rd_tree #(
  parameter int DEPTH = 128
) (
  input  logic           clk,
  input  oal_pkg::word_t leaf [DEPTH],
  output oal_pkg::word_t root
);
  import oal_pkg::*;

  localparam int GRP = 16;
  localparam int NG  = (DEPTH + GRP - 1) / GRP;

  word_t grp_r [NG];
  word_t root_r, root_nxt;

  // OR of one group of sixteen leaves; a short last group skips missing leaves.
  function automatic word_t grp_or(input int g);
    word_t acc;
    acc = '0;
    for (int k = 0; k < GRP; k++) begin
      if (g * GRP + k < DEPTH) acc = acc | leaf[g * GRP + k];
    end
    return acc;
  endfunction

  // First stage: OR each group of sixteen leaves.
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_r[g] <= grp_or(g);
    end
  end

  // Second stage: OR the group results.
  always_comb begin
    root_nxt = '0;
    for (int g = 0; g < NG; g++) root_nxt = root_nxt | grp_r[g];
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
  end

  assign root = root_r;

endmodule

>>> rtl/ordered_array_list.sv
// Top level of the ordered list: operation decode, entry count, cell chain and read path.
//
//   channel | ports                                        | transfer
//   --------+----------------------------------------------+---------------------------
//   input   | start, busy, in_operation/position/value     | edge with start && !busy
//   result  | out_valid, out_read_value/status/item_count  | edge ending out_valid cycle
//
// The result strobe of every operation follows the cell read register and the two
// register stages of the read OR tree, tracked by the flags v1_r, v2_r and out_valid_r.
// All cells shift, hold or load at the input transfer edge, so writes finish at once.
// busy is high while v1_r or v2_r is set after a transfer; a new transfer may coincide with
// the result strobe. Synchronous reset clears the count and the pipeline flags; entries
// stay undefined until written. The receiver cannot stall, so no result is ever held.
`timescale 1ns / 1ps

module ordered_array_list #(
  parameter int LIST_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [7:0]            in_position,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  output logic signed [31:0]    out_read_value,
  output logic [1:0]            out_status,
  output logic [7:0]            out_item_count
);
  import oal_pkg::*;

  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int PW   = (CW > 8) ? CW : 8;
  localparam logic [PW-1:0] DEPTH_X = PW'(LIST_DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic          v1_r, v2_r, out_valid_r;
  logic          rd_ok_r, rd_ok_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    item_count_r;

  logic          accept;
  logic [PW-1:0] pos_x, count_x, cell_pos, count_nxt_x;
  logic          full, empty;
  cell_ctl_t     ctl;

  word_t cell_word [LIST_DEPTH];
  word_t cell_rd   [LIST_DEPTH];
  word_t rd_root;

  assign accept  = start && !busy;
  assign pos_x   = PW'(in_position);
  assign count_x = PW'(count_r);
  assign full    = (count_x == DEPTH_X);
  assign empty   = (count_r == '0);

  // Decode one operation into a cell command, status and next count.
  always_comb begin
    ctl        = '{cmd: CMD_HOLD, rd: 1'b0};
    cell_pos   = pos_x;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    count_nxt  = count_r;
    if (accept) begin
      case (in_operation)
        OP_READ: begin
          if (empty) status_nxt = ST_EMPTY;
          else if (pos_x >= count_x) status_nxt = ST_RANGE;
          else begin
            ctl.rd    = 1'b1;
            rd_ok_nxt = 1'b1;
          end
        end
        OP_INS_AT: begin
          if (full) status_nxt = ST_FULL;
          else if (pos_x > count_x) status_nxt = ST_RANGE;
          else begin
            ctl.cmd   = CMD_INS;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEL_AT: begin
          if (empty) status_nxt = ST_EMPTY;
          else if (pos_x >= count_x) status_nxt = ST_RANGE;
          else begin
            ctl.cmd   = CMD_DEL;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_INS_FIRST: begin
          if (full) status_nxt = ST_FULL;
          else begin
            ctl.cmd   = CMD_INS;
            cell_pos  = '0;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_INS_LAST: begin
          if (full) status_nxt = ST_FULL;
          else begin
            ctl.cmd   = CMD_INS;
            cell_pos  = count_x;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEL_FIRST: begin
          if (empty) status_nxt = ST_EMPTY;
          else begin
            ctl.cmd   = CMD_DEL;
            cell_pos  = '0;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_DEL_LAST: begin
          if (empty) status_nxt = ST_EMPTY;
          else count_nxt = count_r - 1'b1;
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  assign count_nxt_x = PW'(count_nxt);

  // Count and pipeline flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      v1_r        <= accept;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Result fields other than the read word are known at the transfer edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      rd_ok_r      <= rd_ok_nxt;
      item_count_r <= count_nxt_x[7:0];
    end
  end

  // Chain of cells; the ends take the inserted word and their own word.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    word_t lw, rw;
    if (i == 0) begin : g_first
      assign lw = word_t'(in_value);
    end else begin : g_mid_l
      assign lw = cell_word[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign rw = cell_word[i];
    end else begin : g_mid_r
      assign rw = cell_word[i+1];
    end
    oal_cell #(
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (cell_pos),
      .value      (word_t'(in_value)),
      .left_word  (lw),
      .right_word (rw),
      .word       (cell_word[i]),
      .rd_word    (cell_rd[i])
    );
  end

  oal_rd_tree #(
    .DEPTH (LIST_DEPTH)
  ) u_rd_tree (
    .clk  (clk),
    .leaf (cell_rd),
    .root (rd_root)
  );

  assign busy           = v1_r || v2_r;
  assign out_valid      = out_valid_r;
  assign out_read_value = rd_ok_r ? signed'(rd_root) : -32'sd1;
  assign out_status     = status_r;
  assign out_item_count = item_count_r;

  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(count_r) <= DEPTH_X)
    else $error("entry count above list depth");

  // A result strobe follows every input transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("result strobe missing after input transfer");

  // A failed request never carries a read word.
  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_read_value == -32'sd1))
    else $error("failed request with read word");

  // Busy holds off a second transfer while an operation is in flight.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 busy)
    else $error("busy dropped during operation");

endmodule

>>> bench/ordered_array_list_tb.sv
// Self-checking testbench for the ordered list: directed and random operations against a mirror.
`timescale 1ns / 1ps

module ordered_array_list_tb;
  import oal_pkg::*;

  localparam int LIST_DEPTH = 128;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_OPS = 850;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_LIMIT = 200;
  localparam int TAIL_CYCLES = 8;
  localparam int PRINT_LIMIT = 60;

  // One operation as presented on the input ports.
  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         pos;
    logic signed [31:0] val;
  } list_cmd_t;

  // One result as seen on the output ports.
  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         item_count;
  } list_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [2:0]         in_operation = '0;
  logic [7:0]         in_position = '0;
  logic signed [31:0] in_value = '0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_read_value;
  logic [1:0]         out_status;
  logic [7:0]         out_item_count;

  list_cmd_t   cmd_queue[$];
  list_reply_t expected_replies[$];

  // Mirror of the list contents, advanced at each accepted input transfer.
  logic signed [31:0] mirror_words [LIST_DEPTH];
  int unsigned        mirror_count = 0;

  // Entry count as the generator sees it, used to aim positions.
  int unsigned gen_count = 0;

  int  err_count = 0;
  int  total_cmds = 0;
  int  cmds_sent = 0;
  int  quiet_cycles = 0;
  logic took_cmd = 1'b0;

  ordered_array_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_item_count(out_item_count)
  );

  // Free-running clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Print one mismatch line, up to a cap, and count it.
  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Shift entries at and after p up one and store w at p.
  task automatic mirror_open(input int unsigned p, input logic signed [31:0] w);
    int unsigned k;
    for (k = mirror_count; k > p; k--) begin
      mirror_words[k] = mirror_words[k-1];
    end
    mirror_words[p] = w;
    mirror_count++;
  endtask

  // Shift entries after p down one, dropping the entry at p.
  task automatic mirror_close(input int unsigned p);
    int unsigned k;
    for (k = p; k + 1 < mirror_count; k++) begin
      mirror_words[k] = mirror_words[k+1];
    end
    mirror_count--;
  endtask

  // Apply one operation to the mirror and return the result it should produce.
  task automatic apply_list_op(input list_cmd_t c, output list_reply_t r);
    int unsigned p;
    logic        is_full;
    logic        is_empty;
    p = c.pos;
    is_full = (mirror_count >= LIST_DEPTH);
    is_empty = (mirror_count == 0);
    r.read_value = '1;
    r.status = ST_OK;
    case (c.op)
      OP_READ: begin
        if (is_empty) r.status = ST_EMPTY;
        else if (p >= mirror_count) r.status = ST_RANGE;
        else r.read_value = mirror_words[p];
      end
      OP_INS_AT: begin
        if (is_full) r.status = ST_FULL;
        else if (p > mirror_count) r.status = ST_RANGE;
        else mirror_open(p, c.val);
      end
      OP_DEL_AT: begin
        if (is_empty) r.status = ST_EMPTY;
        else if (p >= mirror_count) r.status = ST_RANGE;
        else mirror_close(p);
      end
      OP_INS_FIRST: begin
        if (is_full) r.status = ST_FULL;
        else mirror_open(0, c.val);
      end
      OP_INS_LAST: begin
        if (is_full) r.status = ST_FULL;
        else mirror_open(mirror_count, c.val);
      end
      OP_DEL_FIRST: begin
        if (is_empty) r.status = ST_EMPTY;
        else mirror_close(0);
      end
      OP_DEL_LAST: begin
        if (is_empty) r.status = ST_EMPTY;
        else mirror_count--;
      end
      default: begin
      end
    endcase
    r.item_count = 8'(mirror_count);
  endtask

  // Queue one operation and track how it moves the entry count.
  task automatic add_cmd(input logic [2:0] op, input int unsigned pos,
                         input logic signed [31:0] val);
    list_cmd_t c;
    c.op = op;
    c.pos = 8'(pos);
    c.val = val;
    cmd_queue.push_back(c);
    case (op)
      OP_INS_AT: if (gen_count < LIST_DEPTH && pos <= gen_count) gen_count++;
      OP_INS_FIRST, OP_INS_LAST: if (gen_count < LIST_DEPTH) gen_count++;
      OP_DEL_AT: if (gen_count > 0 && pos < gen_count) gen_count--;
      OP_DEL_FIRST, OP_DEL_LAST: if (gen_count > 0) gen_count--;
      default: begin
      end
    endcase
  endtask

  // Queue one random operation weighted among inserts, deletes and reads, or the unused code.
  task automatic add_random_cmd(input int ins_w, input int del_w, input int rd_w);
    int              r;
    int unsigned     pos;
    logic [2:0]      op;
    logic [31:0]     val;
    r = $urandom_range(0, ins_w + del_w + rd_w + 1);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0: op = OP_INS_AT;
        1: op = OP_INS_FIRST;
        default: op = OP_INS_LAST;
      endcase
    end else if (r < ins_w + del_w) begin
      case ($urandom_range(0, 2))
        0: op = OP_DEL_AT;
        1: op = OP_DEL_FIRST;
        default: op = OP_DEL_LAST;
      endcase
    end else if (r < ins_w + del_w + rd_w) begin
      op = OP_READ;
    end else begin
      op = OP_UNUSED;
    end
    // Mostly legal positions, with the boundary and the whole 8-bit range mixed in.
    if ($urandom_range(0, 99) < 80) begin
      if (op == OP_INS_AT) pos = $urandom_range(0, gen_count);
      else if (gen_count == 0) pos = 0;
      else pos = $urandom_range(0, gen_count - 1);
    end else if ($urandom_range(0, 1) == 0) begin
      pos = gen_count;
    end else begin
      pos = $urandom_range(0, 255);
    end
    case ($urandom_range(0, 19))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'h0000_0000;
      3: val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    add_cmd(op, pos, val);
  endtask

  // Stimulus: a directed opening, random segments, then the end-of-run check.
  initial begin
    int mode;
    int seg;
    int i;
    int drain_wait;

    // Empty-list cases and an insert past the end.
    add_cmd(OP_READ, 0, 32'sd1);
    add_cmd(OP_DEL_AT, 0, 32'sd2);
    add_cmd(OP_DEL_FIRST, 0, 32'sd3);
    add_cmd(OP_DEL_LAST, 0, 32'sd4);
    add_cmd(OP_INS_AT, 1, 32'sd5);
    // Build a short list with extreme words, including an insert at the end.
    add_cmd(OP_INS_AT, 0, 32'sh8000_0000);
    add_cmd(OP_INS_FIRST, 0, 32'sh7FFF_FFFF);
    add_cmd(OP_INS_LAST, 255, 32'shFFFF_FFFF);
    add_cmd(OP_INS_AT, 1, 32'sh0000_0000);
    add_cmd(OP_INS_AT, 4, 32'sh5A5A_5A5A);
    add_cmd(OP_INS_AT, 255, 32'sh1234_5678);
    // Reads inside and past the end.
    add_cmd(OP_READ, 0, 32'sd0);
    add_cmd(OP_READ, 4, 32'sd0);
    add_cmd(OP_READ, 5, 32'sd0);
    add_cmd(OP_READ, 255, 32'sd0);
    // Deletes of every kind, range errors and the unused code.
    add_cmd(OP_DEL_AT, 5, 32'sd0);
    add_cmd(OP_DEL_AT, 2, 32'sd0);
    add_cmd(OP_UNUSED, 255, 32'shFFFF_FFFF);
    add_cmd(OP_DEL_FIRST, 0, 32'sd0);
    add_cmd(OP_DEL_LAST, 0, 32'sd0);
    add_cmd(OP_READ, 1, 32'sd0);
    add_cmd(OP_DEL_AT, 200, 32'sd0);
    add_cmd(OP_DEL_AT, 0, 32'sd0);
    add_cmd(OP_DEL_AT, 0, 32'sd0);
    add_cmd(OP_READ, 0, 32'sd0);

    // Random segments: fill to full, drain to empty, or biased mixes.
    total_cmds = cmd_queue.size() + RANDOM_OPS;
    while (cmd_queue.size() < total_cmds) begin
      mode = $urandom_range(0, 9);
      seg = $urandom_range(8, 40);
      if (mode == 0) begin
        while (gen_count < LIST_DEPTH) add_random_cmd(90, 0, 10);
        for (i = 0; i < 3; i++) add_random_cmd(100, 0, 0);
      end else if (mode == 1) begin
        while (gen_count > 0) add_random_cmd(0, 90, 10);
        for (i = 0; i < 3; i++) add_random_cmd(0, 60, 40);
      end else if (mode < 5) begin
        for (i = 0; i < seg; i++) add_random_cmd(60, 20, 20);
      end else if (mode < 8) begin
        for (i = 0; i < seg; i++) add_random_cmd(20, 60, 20);
      end else begin
        for (i = 0; i < seg; i++) add_random_cmd(33, 33, 33);
      end
    end
    total_cmds = cmd_queue.size();

    // Reset held from the start, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until everything has been handed over and answered.
    while (cmd_queue.size() != 0 || start) @(posedge clk);
    drain_wait = 0;
    while (expected_replies.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver: presents the next operation at the falling edge and holds it until transfer.
  always @(negedge clk) begin
    list_cmd_t c;
    int        idle_pct;
    if (cmds_sent < total_cmds / 3) idle_pct = 21;
    else if (cmds_sent < (2 * total_cmds) / 3) idle_pct = 75;
    else idle_pct = 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_cmd) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        in_operation <= c.op;
        in_position <= c.pos;
        in_value <= c.val;
        cmds_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result strobes, predicts on input transfers, and watches for a hang.
  always @(posedge clk) begin
    list_cmd_t   c;
    list_reply_t exp_r;
    list_reply_t got_r;
    if (rst_n) begin
      // Check the strobed result against the oldest expectation.
      if (out_valid === 1'b1) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result strobe with no outstanding operation");
        end else begin
          exp_r = expected_replies.pop_front();
          got_r.read_value = out_read_value;
          got_r.status = out_status;
          got_r.item_count = out_item_count;
          if (got_r.read_value !== exp_r.read_value) begin
            report_mismatch($sformatf("read_value got %h expected %h",
                                      got_r.read_value, exp_r.read_value));
          end
          if (got_r.status !== exp_r.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got_r.status, exp_r.status));
          end
          if (got_r.item_count !== exp_r.item_count) begin
            report_mismatch($sformatf("item_count got %0d expected %0d",
                                      got_r.item_count, exp_r.item_count));
          end
        end
      end
      // Predict the result of an operation taken at this edge.
      if (start && busy === 1'b0) begin
        c.op = in_operation;
        c.pos = in_position;
        c.val = in_value;
        apply_list_op(c, exp_r);
        expected_replies.push_back(exp_r);
      end
      // Watchdog on cycles with no transfer on either side.
      if ((start && busy === 1'b0) || out_valid === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
    took_cmd <= rst_n && start && (busy === 1'b0);
  end

endmodule

>>> files.f
rtl/oal_pkg.sv
rtl/oal_cell.sv
rtl/oal_rd_tree.sv
rtl/ordered_array_list.sv
bench/ordered_array_list_tb.sv
